### rtl/c8ic_pkg.sv
package c8ic_pkg;

    // Sizes of the machine
    localparam int MEM_BYTES     = 4096;
    localparam int ADDR_W        = $clog2(MEM_BYTES);
    localparam int PROGRAM_START = 512;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int FB_BYTES      = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
    localparam int FB_AW         = $clog2(FB_BYTES);
    localparam int NUM_V         = 16;
    localparam int FONT_BYTES    = 80;

    // Hex font, five bytes per digit
    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Host operations
    typedef enum logic [1:0] {
        OP_MEM_WR = 2'd0,
        OP_KEY    = 2'd1,
        OP_EXEC   = 2'd2,
        OP_FB_RD  = 2'd3
    } t_op;

    // Instruction groups (top nibble)
    typedef enum logic [3:0] {
        G_SYS = 4'h0, G_JP = 4'h1, G_CALL = 4'h2, G_SE_NN = 4'h3,
        G_SNE_NN = 4'h4, G_SE_XY = 4'h5, G_LD_NN = 4'h6, G_ADD_NN = 4'h7,
        G_ALU = 4'h8, G_SNE_XY = 4'h9, G_LD_I = 4'hA, G_JP_V0 = 4'hB,
        G_RND = 4'hC, G_DRW = 4'hD, G_KEY = 4'hE, G_MISC = 4'hF
    } t_grp;

    localparam logic [11:0] SYS_CLS  = 12'h0E0;
    localparam logic [11:0] SYS_RET  = 12'h0EE;
    localparam logic [15:0] ADDR_MAX = 16'h0FFF;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] MISC_GET_DT = 8'h07;
    localparam logic [7:0] MISC_WAIT   = 8'h0A;
    localparam logic [7:0] MISC_SET_DT = 8'h15;
    localparam logic [7:0] MISC_SET_ST = 8'h18;
    localparam logic [7:0] MISC_ADD_I  = 8'h1E;
    localparam logic [7:0] MISC_FONT   = 8'h29;
    localparam logic [7:0] MISC_BCD    = 8'h33;
    localparam logic [7:0] MISC_STORE  = 8'h55;
    localparam logic [7:0] MISC_LOAD   = 8'h65;

    typedef struct packed {
        t_op              operation;
        logic [ADDR_W-1:0] address;
        logic [7:0]       data_byte;
        logic [3:0]       key_index;
        logic             key_down;
        logic [7:0]       random_byte;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] program_counter;
        logic [15:0]      executed_opcode;
        logic             draw_flag;
        logic             waiting_for_key;
        logic             sound_on;
        logic [7:0]       read_data;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic init_wr;
        logic cap_item;
        logic host;
        logic fetch_hi;
        logic fetch_lo;
        logic cap_lo;
        logic cap_vx;
        logic cap_vy;
        logic exec;
        logic flag_wr;
        logic cls_step;
        logic drw_rd;
        logic drw_spr;
        logic drw_b0;
        logic drw_b1;
        logic bcd_wr;
        logic st_rd;
        logic st_wr;
        logic ld_rd;
        logic ld_wr;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic init_last;
        logic op_exec;
        logic run;
        logic is_cls;
        logic is_drw;
        logic n_zero;
        logic is_bcd;
        logic is_st;
        logic is_ld;
        logic need_flag;
        logic cls_last;
        logic row_last;
        logic bcd_last;
        logic reg_last;
    } t_stat;

endpackage

### rtl/c8ic_if.sv
interface c8ic_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [c8ic_pkg::ADDR_W-1:0]   address;
    logic [7:0]                    data_byte;
    logic [3:0]                    key_index;
    logic                          key_down;
    logic [7:0]                    random_byte;

    modport source (output valid, operation, address, data_byte, key_index, key_down,
                    random_byte, input ready);
    modport sink (input valid, operation, address, data_byte, key_index, key_down,
                  random_byte, output ready);
endinterface

interface c8ic_out_if;
    logic                          valid;
    logic                          ready;
    logic [c8ic_pkg::ADDR_W-1:0]   program_counter;
    logic [15:0]                   executed_opcode;
    logic                          draw_flag;
    logic                          waiting_for_key;
    logic                          sound_on;
    logic [7:0]                    read_data;

    modport source (output valid, program_counter, executed_opcode, draw_flag,
                    waiting_for_key, sound_on, read_data, input ready);
    modport sink (input valid, program_counter, executed_opcode, draw_flag,
                  waiting_for_key, sound_on, read_data, output ready);
endinterface

### rtl/chip8_instruction_core_unit.sv
// Steps: memory write, key event, display read and stalled execute go through
//   the host step to the result; an execute fetches, reads Vx and Vy, executes;
//   a clear then walks the display, a draw each row, FX55/FX65 each register.
// Throughput: one item at a time; the shared memory ports set the per-row cost.
// Reset: a pass over every memory address loads the font and clears memory and
//   display; no transaction is accepted until it ends.
module chip8_instruction_core_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c8ic_in_if.sink    i_in,
    c8ic_out_if.source o_out
);

    c8ic_pkg::t_item item;
    c8ic_pkg::t_cmd  cmd;
    c8ic_pkg::t_stat stat;
    c8ic_pkg::t_res  res;

    // Pack the incoming transaction
    always_comb begin
        item.operation   = c8ic_pkg::t_op'(i_in.operation);
        item.address     = i_in.address;
        item.data_byte   = i_in.data_byte;
        item.key_index   = i_in.key_index;
        item.key_down    = i_in.key_down;
        item.random_byte = i_in.random_byte;
    end

    c8ic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    c8ic_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (res)
    );

    // Drive the result channel
    assign o_out.program_counter = res.program_counter;
    assign o_out.executed_opcode = res.executed_opcode;
    assign o_out.draw_flag       = res.draw_flag;
    assign o_out.waiting_for_key = res.waiting_for_key;
    assign o_out.sound_on        = res.sound_on;
    assign o_out.read_data       = res.read_data;

endmodule

### rtl/c8ic_dp.sv
module c8ic_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c8ic_pkg::t_item  i_item,
    input  c8ic_pkg::t_cmd   i_cmd,
    output c8ic_pkg::t_stat  o_stat,
    output c8ic_pkg::t_res   o_res
);

    localparam int AW = c8ic_pkg::ADDR_W;
    localparam int SW = c8ic_pkg::SP_W;

    // Storage
    logic [7:0]    r_mem [c8ic_pkg::MEM_BYTES];
    logic [7:0]    r_mem_q;
    logic [7:0]    r_fb [c8ic_pkg::FB_BYTES];
    logic [7:0]    r_fb_q;
    logic [7:0]    r_v [c8ic_pkg::NUM_V];
    logic [7:0]    r_v_q;
    logic [AW-1:0] r_stack [c8ic_pkg::STACK_DEPTH];

    // Machine registers
    logic [SW-1:0] r_sp;
    logic [15:0]   r_i;
    logic [AW-1:0] r_pc;
    logic [7:0]    r_dt;
    logic [7:0]    r_st;
    logic [15:0]   r_keys;
    logic          r_run;

    // Working registers
    c8ic_pkg::t_item r_item;
    c8ic_pkg::t_res  r_res;
    logic [15:0]   r_op;
    logic [7:0]    r_vx;
    logic [7:0]    r_vy;
    logic [7:0]    r_sprite;
    logic [AW-1:0] r_cnt;
    logic          r_flag;
    logic          r_drew;
    logic          r_exe;

    c8ic_pkg::t_grp grp;
    logic [3:0]    op_x, op_y, op_n;
    logic [7:0]    op_nn;
    logic [AW-1:0] op_nnn;
    logic [AW-1:0] idx_addr;
    logic [4:0]    fb_row;
    logic [2:0]    col0, col1;
    logic [15:0]   spr16;
    logic [SW-1:0] sp_inc, sp_dec;
    logic [AW-1:0] pc2;
    logic [7:0]    st_next;
    logic [7:0]    bcd_rem;
    logic [1:0]    bcd_h;
    logic [15:0]   bcd_prod;
    logic [3:0]    bcd_t;
    logic [7:0]    bcd_o;
    logic [7:0]    bcd_digit;
    logic [7:0]    init_byte;

    logic [AW-1:0] mem_ra, mem_wa;
    logic          mem_we;
    logic [7:0]    mem_wd;
    logic [c8ic_pkg::FB_AW-1:0] fb_ra, fb_wa;
    logic          fb_we;
    logic [7:0]    fb_wd;
    logic [3:0]    v_ra, v_wa;
    logic          v_we;
    logic [7:0]    v_wd;

    // Execute results
    logic [AW-1:0] ex_pc;
    logic          ex_vwe;
    logic [7:0]    ex_vd;
    logic          ex_flag;
    logic [15:0]   ex_i;
    logic [SW-1:0] ex_sp;
    logic          ex_push;
    logic [7:0]    ex_dt, ex_st;
    logic          ex_run;
    logic [8:0]    sum9;
    logic [16:0]   sum_i;
    logic          key_hit;

    // Decode fields
    assign grp      = c8ic_pkg::t_grp'(r_op[15:12]);
    assign op_x     = r_op[11:8];
    assign op_y     = r_op[7:4];
    assign op_n     = r_op[3:0];
    assign op_nn    = r_op[7:0];
    assign op_nnn   = r_op[AW-1:0];
    assign idx_addr = r_i[AW-1:0] + r_cnt;
    assign fb_row   = r_vy[4:0] + r_cnt[4:0];
    assign col0     = r_vx[5:3];
    assign col1     = col0 + 3'd1;
    assign spr16    = {r_sprite, 8'h00} >> r_vx[2:0];
    assign pc2      = r_pc + AW'(2);
    assign sp_inc   = (r_sp == SW'(c8ic_pkg::STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec   = (r_sp == '0) ? SW'(c8ic_pkg::STACK_DEPTH - 1) : r_sp - 1'b1;
    assign st_next  = r_st - {7'd0, (r_exe && (r_st != 8'd0))};
    assign key_hit  = r_keys[r_vx[3:0]];
    assign init_byte = (r_cnt < AW'(c8ic_pkg::FONT_BYTES)) ?
                       c8ic_pkg::FONT_ROM[r_cnt[6:0]] : 8'h00;

    // Split Vx into decimal digits
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h   = 2'd2;
            bcd_rem = r_vx - 8'd200;
        end else if (r_vx >= 8'd100) begin
            bcd_h   = 2'd1;
            bcd_rem = r_vx - 8'd100;
        end else begin
            bcd_h   = 2'd0;
            bcd_rem = r_vx;
        end
        bcd_prod = 16'(bcd_rem) * 16'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = bcd_rem - (8'(bcd_t) * 8'd10);
        case (r_cnt[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = bcd_o;
        endcase
    end

    // Combinational part of each instruction
    always_comb begin
        ex_pc   = pc2;
        ex_vwe  = 1'b0;
        ex_vd   = 8'h00;
        ex_flag = 1'b0;
        ex_i    = r_i;
        ex_sp   = r_sp;
        ex_push = 1'b0;
        ex_dt   = r_dt;
        ex_st   = r_st;
        ex_run  = r_run;
        sum9    = {1'b0, r_vx} + {1'b0, r_vy};
        sum_i   = {1'b0, r_i} + 17'(r_vx);
        case (grp)
            c8ic_pkg::G_SYS: begin
                if (op_nnn == c8ic_pkg::SYS_RET) begin
                    ex_sp = sp_dec;
                    ex_pc = r_stack[sp_dec];
                end
            end
            c8ic_pkg::G_JP:     ex_pc = op_nnn;
            c8ic_pkg::G_CALL: begin
                ex_push = 1'b1;
                ex_sp   = sp_inc;
                ex_pc   = op_nnn;
            end
            c8ic_pkg::G_SE_NN:  if (r_vx == op_nn) ex_pc = r_pc + AW'(4);
            c8ic_pkg::G_SNE_NN: if (r_vx != op_nn) ex_pc = r_pc + AW'(4);
            c8ic_pkg::G_SE_XY:  if (r_vx == r_vy) ex_pc = r_pc + AW'(4);
            c8ic_pkg::G_SNE_XY: if (r_vx != r_vy) ex_pc = r_pc + AW'(4);
            c8ic_pkg::G_LD_NN: begin
                ex_vwe = 1'b1;
                ex_vd  = op_nn;
            end
            c8ic_pkg::G_ADD_NN: begin
                ex_vwe = 1'b1;
                ex_vd  = r_vx + op_nn;
            end
            c8ic_pkg::G_ALU: begin
                case (op_n)
                    c8ic_pkg::ALU_MOV: begin ex_vwe = 1'b1; ex_vd = r_vy; end
                    c8ic_pkg::ALU_OR:  begin ex_vwe = 1'b1; ex_vd = r_vx | r_vy; end
                    c8ic_pkg::ALU_AND: begin ex_vwe = 1'b1; ex_vd = r_vx & r_vy; end
                    c8ic_pkg::ALU_XOR: begin ex_vwe = 1'b1; ex_vd = r_vx ^ r_vy; end
                    c8ic_pkg::ALU_ADD: begin
                        ex_vwe  = 1'b1;
                        ex_vd   = sum9[7:0];
                        ex_flag = sum9[8];
                    end
                    c8ic_pkg::ALU_SUB: begin
                        ex_vwe  = 1'b1;
                        ex_vd   = r_vx - r_vy;
                        ex_flag = r_vx > r_vy;
                    end
                    c8ic_pkg::ALU_SHR: begin
                        ex_vwe  = 1'b1;
                        ex_vd   = {1'b0, r_vx[7:1]};
                        ex_flag = r_vx[0];
                    end
                    c8ic_pkg::ALU_SUBN: begin
                        ex_vwe  = 1'b1;
                        ex_vd   = r_vy - r_vx;
                        ex_flag = r_vy > r_vx;
                    end
                    c8ic_pkg::ALU_SHL: begin
                        ex_vwe  = 1'b1;
                        ex_vd   = {r_vx[6:0], 1'b0};
                        ex_flag = r_vx[7];
                    end
                    default: ;
                endcase
            end
            c8ic_pkg::G_LD_I:  ex_i = {{(16 - AW){1'b0}}, op_nnn};
            c8ic_pkg::G_JP_V0: ex_pc = op_nnn + AW'(r_vy);
            c8ic_pkg::G_RND: begin
                ex_vwe = 1'b1;
                ex_vd  = r_item.random_byte & op_nn;
            end
            c8ic_pkg::G_KEY: begin
                if (op_nn == c8ic_pkg::KEY_DOWN) begin
                    if (key_hit) ex_pc = r_pc + AW'(4);
                end else if (op_nn == c8ic_pkg::KEY_UP) begin
                    if (!key_hit) ex_pc = r_pc + AW'(4);
                end
            end
            c8ic_pkg::G_MISC: begin
                case (op_nn)
                    c8ic_pkg::MISC_GET_DT: begin ex_vwe = 1'b1; ex_vd = r_dt; end
                    c8ic_pkg::MISC_WAIT:   ex_run = 1'b0;
                    c8ic_pkg::MISC_SET_DT: ex_dt = r_vx;
                    c8ic_pkg::MISC_SET_ST: ex_st = r_vx;
                    c8ic_pkg::MISC_ADD_I: begin
                        ex_i    = sum_i[15:0];
                        ex_flag = sum_i > {1'b0, c8ic_pkg::ADDR_MAX};
                    end
                    c8ic_pkg::MISC_FONT:   ex_i = 16'(r_vx) * 16'd5;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Main memory port selection
    always_comb begin
        mem_ra = r_pc;
        if (i_cmd.fetch_lo) begin
            mem_ra = r_pc + AW'(1);
        end else if (i_cmd.drw_rd || i_cmd.ld_rd) begin
            mem_ra = idx_addr;
        end
        mem_we = 1'b0;
        mem_wa = idx_addr;
        mem_wd = r_v_q;
        if (i_cmd.init_wr) begin
            mem_we = 1'b1;
            mem_wa = r_cnt;
            mem_wd = init_byte;
        end else if (i_cmd.host && r_item.operation == c8ic_pkg::OP_MEM_WR) begin
            mem_we = 1'b1;
            mem_wa = r_item.address;
            mem_wd = r_item.data_byte;
        end else if (i_cmd.bcd_wr) begin
            mem_we = 1'b1;
            mem_wd = bcd_digit;
        end else if (i_cmd.st_wr) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    // Frame buffer port selection
    always_comb begin
        fb_ra = r_item.address[c8ic_pkg::FB_AW-1:0];
        if (i_cmd.cls_step) begin
            fb_ra = r_cnt[c8ic_pkg::FB_AW-1:0];
        end else if (i_cmd.drw_spr) begin
            fb_ra = {fb_row, col0};
        end else if (i_cmd.drw_b0) begin
            fb_ra = {fb_row, col1};
        end
        fb_we = 1'b0;
        fb_wa = r_cnt[c8ic_pkg::FB_AW-1:0];
        fb_wd = 8'h00;
        if (i_cmd.init_wr) begin
            fb_we = 1'b1;
        end else if (i_cmd.cls_step) begin
            fb_we = r_cnt < AW'(c8ic_pkg::FB_BYTES);
        end else if (i_cmd.drw_b0) begin
            fb_we = 1'b1;
            fb_wa = {fb_row, col0};
            fb_wd = r_fb_q ^ spr16[15:8];
        end else if (i_cmd.drw_b1) begin
            fb_we = 1'b1;
            fb_wa = {fb_row, col1};
            fb_wd = r_fb_q ^ spr16[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fb[fb_wa] <= fb_wd;
        end
        r_fb_q <= r_fb[fb_ra];
    end

    // Register file port selection
    always_comb begin
        v_ra = op_x;
        if (i_cmd.cap_vx) begin
            v_ra = (grp == c8ic_pkg::G_JP_V0) ? 4'h0 : op_y;
        end else if (i_cmd.st_rd) begin
            v_ra = r_cnt[3:0];
        end
        v_we = 1'b0;
        v_wa = op_x;
        v_wd = ex_vd;
        if (i_cmd.exec) begin
            v_we = ex_vwe;
        end else if (i_cmd.flag_wr) begin
            v_we = 1'b1;
            v_wa = 4'hF;
            v_wd = {7'd0, r_flag};
        end else if (i_cmd.ld_wr) begin
            v_we = 1'b1;
            v_wa = r_cnt[3:0];
            v_wd = r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < c8ic_pkg::NUM_V; k++) begin
                r_v[k] <= 8'h00;
            end
        end else if (v_we) begin
            r_v[v_wa] <= v_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v_q <= r_v[v_ra];
    end

    // Machine state and sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_i    <= 16'h0000;
            r_pc   <= AW'(c8ic_pkg::PROGRAM_START);
            r_dt   <= 8'h00;
            r_st   <= 8'h00;
            r_keys <= 16'h0000;
            r_run  <= 1'b1;
            r_cnt  <= '0;
            r_flag <= 1'b0;
            r_drew <= 1'b0;
            r_exe  <= 1'b0;
            for (int k = 0; k < c8ic_pkg::STACK_DEPTH; k++) begin
                r_stack[k] <= '0;
            end
        end else begin
            if (i_cmd.cap_item) begin
                r_drew <= 1'b0;
                r_exe  <= 1'b0;
            end
            if (i_cmd.host && r_item.operation == c8ic_pkg::OP_KEY) begin
                r_keys[r_item.key_index] <= r_item.key_down;
                if (r_item.key_down) begin
                    r_run <= 1'b1;
                end
            end
            if (i_cmd.fetch_hi) begin
                r_exe <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_pc   <= ex_pc;
                r_sp   <= ex_sp;
                r_i    <= ex_i;
                r_dt   <= ex_dt;
                r_st   <= ex_st;
                r_run  <= ex_run;
                r_flag <= ex_flag;
                r_cnt  <= '0;
                if (ex_push) begin
                    r_stack[r_sp] <= pc2;
                end
            end
            if (i_cmd.cls_step && r_cnt != '0 && r_fb_q != 8'h00) begin
                r_drew <= 1'b1;
            end
            if (i_cmd.drw_b0) begin
                if (r_sprite != 8'h00) r_drew <= 1'b1;
                if ((r_fb_q & spr16[15:8]) != 8'h00) r_flag <= 1'b1;
            end
            if (i_cmd.drw_b1 && (r_fb_q & spr16[7:0]) != 8'h00) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.init_wr || i_cmd.cls_step || i_cmd.drw_b1 || i_cmd.bcd_wr ||
                i_cmd.st_wr || i_cmd.ld_wr) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.finish && r_exe) begin
                if (r_dt != 8'h00) r_dt <= r_dt - 8'd1;
                r_st <= st_next;
            end
        end
    end

    // Captured item, opcode, operands and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) r_item <= i_item;
        if (i_cmd.fetch_lo) r_op[15:8] <= r_mem_q;
        if (i_cmd.cap_lo)   r_op[7:0] <= r_mem_q;
        if (i_cmd.cap_vx)   r_vx <= r_v_q;
        if (i_cmd.cap_vy)   r_vy <= r_v_q;
        if (i_cmd.drw_spr)  r_sprite <= r_mem_q;
        if (i_cmd.finish) begin
            r_res.program_counter <= r_pc;
            r_res.executed_opcode <= r_exe ? r_op : 16'h0000;
            r_res.draw_flag       <= r_drew;
            r_res.waiting_for_key <= !r_run;
            r_res.sound_on        <= st_next != 8'h00;
            r_res.read_data       <= (r_item.operation == c8ic_pkg::OP_FB_RD) ?
                                     r_fb_q : 8'h00;
        end
    end

    assign o_res = r_res;

    // Status for the controller
    always_comb begin
        o_stat.init_last = r_cnt == AW'(c8ic_pkg::MEM_BYTES - 1);
        o_stat.op_exec   = r_item.operation == c8ic_pkg::OP_EXEC;
        o_stat.run       = r_run;
        o_stat.is_cls    = (grp == c8ic_pkg::G_SYS) && (op_nnn == c8ic_pkg::SYS_CLS);
        o_stat.is_drw    = grp == c8ic_pkg::G_DRW;
        o_stat.n_zero    = op_n == 4'h0;
        o_stat.is_bcd    = (grp == c8ic_pkg::G_MISC) && (op_nn == c8ic_pkg::MISC_BCD);
        o_stat.is_st     = (grp == c8ic_pkg::G_MISC) && (op_nn == c8ic_pkg::MISC_STORE);
        o_stat.is_ld     = (grp == c8ic_pkg::G_MISC) && (op_nn == c8ic_pkg::MISC_LOAD);
        o_stat.need_flag = ((grp == c8ic_pkg::G_ALU) &&
                            (op_n == c8ic_pkg::ALU_ADD || op_n == c8ic_pkg::ALU_SUB ||
                             op_n == c8ic_pkg::ALU_SHR || op_n == c8ic_pkg::ALU_SUBN ||
                             op_n == c8ic_pkg::ALU_SHL)) ||
                           ((grp == c8ic_pkg::G_MISC) && (op_nn == c8ic_pkg::MISC_ADD_I));
        o_stat.cls_last  = r_cnt == AW'(c8ic_pkg::FB_BYTES);
        o_stat.row_last  = r_cnt[3:0] == (op_n - 4'd1);
        o_stat.bcd_last  = r_cnt == AW'(2);
        o_stat.reg_last  = r_cnt[3:0] == op_x;
    end

endmodule

### rtl/c8ic_ctrl.sv
module c8ic_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  c8ic_pkg::t_stat  i_stat,
    output c8ic_pkg::t_cmd   o_cmd
);

    typedef enum logic [20:0] {
        S_INIT     = 21'h000001,
        S_IDLE     = 21'h000002,
        S_HOST     = 21'h000004,
        S_FETCH_HI = 21'h000008,
        S_FETCH_LO = 21'h000010,
        S_CAP_LO   = 21'h000020,
        S_CAP_VX   = 21'h000040,
        S_CAP_VY   = 21'h000080,
        S_EXEC     = 21'h000100,
        S_FLAG     = 21'h000200,
        S_CLS      = 21'h000400,
        S_DRW_RD   = 21'h000800,
        S_DRW_SPR  = 21'h001000,
        S_DRW_B0   = 21'h002000,
        S_DRW_B1   = 21'h004000,
        S_BCD      = 21'h008000,
        S_ST_RD    = 21'h010000,
        S_ST_WR    = 21'h020000,
        S_LD_RD    = 21'h040000,
        S_LD_WR    = 21'h080000,
        S_FINISH   = 21'h100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_item = 1'b1;
                    n_state = S_HOST;
                end
            end
            S_HOST: begin
                o_cmd.host = 1'b1;
                n_state = (i_stat.op_exec && i_stat.run) ? S_FETCH_HI : S_FINISH;
            end
            S_FETCH_HI: begin o_cmd.fetch_hi = 1'b1; n_state = S_FETCH_LO; end
            S_FETCH_LO: begin o_cmd.fetch_lo = 1'b1; n_state = S_CAP_LO; end
            S_CAP_LO:   begin o_cmd.cap_lo = 1'b1;   n_state = S_CAP_VX; end
            S_CAP_VX:   begin o_cmd.cap_vx = 1'b1;   n_state = S_CAP_VY; end
            S_CAP_VY:   begin o_cmd.cap_vy = 1'b1;   n_state = S_EXEC; end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.is_cls)         n_state = S_CLS;
                else if (i_stat.is_drw)    n_state = i_stat.n_zero ? S_FLAG : S_DRW_RD;
                else if (i_stat.is_bcd)    n_state = S_BCD;
                else if (i_stat.is_st)     n_state = S_ST_RD;
                else if (i_stat.is_ld)     n_state = S_LD_RD;
                else if (i_stat.need_flag) n_state = S_FLAG;
                else                       n_state = S_FINISH;
            end
            S_FLAG: begin o_cmd.flag_wr = 1'b1; n_state = S_FINISH; end
            S_CLS: begin
                o_cmd.cls_step = 1'b1;
                if (i_stat.cls_last) n_state = S_FINISH;
            end
            S_DRW_RD:  begin o_cmd.drw_rd = 1'b1;  n_state = S_DRW_SPR; end
            S_DRW_SPR: begin o_cmd.drw_spr = 1'b1; n_state = S_DRW_B0; end
            S_DRW_B0:  begin o_cmd.drw_b0 = 1'b1;  n_state = S_DRW_B1; end
            S_DRW_B1: begin
                o_cmd.drw_b1 = 1'b1;
                n_state = i_stat.row_last ? S_FLAG : S_DRW_RD;
            end
            S_BCD: begin
                o_cmd.bcd_wr = 1'b1;
                if (i_stat.bcd_last) n_state = S_FINISH;
            end
            S_ST_RD: begin o_cmd.st_rd = 1'b1; n_state = S_ST_WR; end
            S_ST_WR: begin
                o_cmd.st_wr = 1'b1;
                n_state = i_stat.reg_last ? S_FINISH : S_ST_RD;
            end
            S_LD_RD: begin o_cmd.ld_rd = 1'b1; n_state = S_LD_WR; end
            S_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                n_state = i_stat.reg_last ? S_FINISH : S_LD_RD;
            end
            S_FINISH: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken transaction");

    a_finish_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished item produced no result");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while an item is in work");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

// Expected-result store plus a CHIP-8 machine that advances on each accepted transaction
class c8_scoreboard;
    logic [7:0]  mem [c8ic_pkg::MEM_BYTES];
    logic [7:0]  vreg [c8ic_pkg::NUM_V];
    logic [11:0] stk [c8ic_pkg::STACK_DEPTH];
    int unsigned sp;
    logic [15:0] ireg;
    logic [11:0] pc;
    logic [7:0]  dt;
    logic [7:0]  st;
    bit          fb [c8ic_pkg::SCREEN_WIDTH*c8ic_pkg::SCREEN_HEIGHT];
    bit          keys [16];
    bit          run;
    c8ic_pkg::t_res pending [$];
    int          errors;
    int          checked;

    function new();
        for (int i = 0; i < c8ic_pkg::MEM_BYTES; i++)
            mem[i] = (i < c8ic_pkg::FONT_BYTES) ? c8ic_pkg::FONT_ROM[i] : 8'h00;
        for (int i = 0; i < c8ic_pkg::NUM_V; i++) vreg[i] = '0;
        for (int i = 0; i < c8ic_pkg::STACK_DEPTH; i++) stk[i] = '0;
        foreach (fb[i]) fb[i] = 0;
        foreach (keys[i]) keys[i] = 0;
        sp = 0; ireg = '0; pc = 12'(c8ic_pkg::PROGRAM_START); dt = '0; st = '0; run = 1;
        errors = 0; checked = 0;
    endfunction

    function void skip_when(bit c);
        if (c) pc = pc + 12'd2;
    endfunction

    function void run_alu(int x, int y, logic [3:0] sub);
        logic [8:0] r;
        logic       f;
        logic [7:0] a;
        logic [7:0] b;
        a = vreg[x]; b = vreg[y];
        case (sub)
            c8ic_pkg::ALU_MOV: begin vreg[x] = b; return; end
            c8ic_pkg::ALU_OR:  begin vreg[x] = a | b; return; end
            c8ic_pkg::ALU_AND: begin vreg[x] = a & b; return; end
            c8ic_pkg::ALU_XOR: begin vreg[x] = a ^ b; return; end
            c8ic_pkg::ALU_ADD:  begin r = a + b; f = r[8]; end
            c8ic_pkg::ALU_SUB:  begin r = a - b; f = a > b; end
            c8ic_pkg::ALU_SHR:  begin r = a >> 1; f = a[0]; end
            c8ic_pkg::ALU_SUBN: begin r = b - a; f = b > a; end
            c8ic_pkg::ALU_SHL:  begin r = {a, 1'b0}; f = a[7]; end
            default: return;
        endcase
        vreg[x] = r[7:0];
        vreg[15] = {7'd0, f};
    endfunction

    function bit draw(int x, int y, int rows);
        bit   changed;
        int   px;
        int   py;
        logic [7:0] bits;
        changed = 0;
        vreg[15] = 0;
        for (int r = 0; r < rows; r++) begin
            bits = mem[(ireg + r) & 16'hFFF];
            py = (vreg[y] + r) % c8ic_pkg::SCREEN_HEIGHT;
            for (int c = 0; c < 8; c++) begin
                if (bits[7-c]) begin
                    px = (vreg[x] + c) % c8ic_pkg::SCREEN_WIDTH;
                    if (fb[py*c8ic_pkg::SCREEN_WIDTH+px]) vreg[15] = 1;
                    fb[py*c8ic_pkg::SCREEN_WIDTH+px] ^= 1;
                    changed = 1;
                end
            end
        end
        return changed;
    endfunction

    function void run_misc(int x, logic [7:0] sub);
        logic [16:0] sum;
        case (sub)
            c8ic_pkg::MISC_GET_DT: vreg[x] = dt;
            c8ic_pkg::MISC_WAIT:   run = 0;
            c8ic_pkg::MISC_SET_DT: dt = vreg[x];
            c8ic_pkg::MISC_SET_ST: st = vreg[x];
            c8ic_pkg::MISC_ADD_I: begin
                sum = ireg + vreg[x];
                vreg[15] = {7'd0, sum > 17'hFFF};
                ireg = sum[15:0];
            end
            c8ic_pkg::MISC_FONT: ireg = vreg[x] * 16'd5;
            c8ic_pkg::MISC_BCD: begin
                mem[ireg[11:0]]         = vreg[x] / 100;
                mem[ireg[11:0] + 12'd1] = (vreg[x] / 10) % 10;
                mem[ireg[11:0] + 12'd2] = vreg[x] % 10;
            end
            c8ic_pkg::MISC_STORE:
                for (int i = 0; i <= x; i++) mem[(ireg + i) & 16'hFFF] = vreg[i];
            c8ic_pkg::MISC_LOAD:
                for (int i = 0; i <= x; i++) vreg[i] = mem[(ireg + i) & 16'hFFF];
            default: ;
        endcase
    endfunction

    // Advance the machine by one accepted transaction and queue its result
    function void note_item(c8ic_pkg::t_item it);
        c8ic_pkg::t_res res;
        logic [15:0] op;
        int         x;
        int         y;
        int         base;
        logic [7:0] nn;
        res = '0;
        case (it.operation)
            c8ic_pkg::OP_MEM_WR: mem[it.address] = it.data_byte;
            c8ic_pkg::OP_KEY: begin
                keys[it.key_index] = it.key_down;
                if (it.key_down) run = 1;
            end
            c8ic_pkg::OP_EXEC: if (run) begin
                op = {mem[pc], mem[pc + 12'd1]};
                x = op[11:8]; y = op[7:4]; nn = op[7:0];
                pc = pc + 12'd2;
                case (c8ic_pkg::t_grp'(op[15:12]))
                    c8ic_pkg::G_SYS: begin
                        if (op[11:0] == c8ic_pkg::SYS_CLS) begin
                            foreach (fb[i]) begin
                                if (fb[i]) res.draw_flag = 1;
                                fb[i] = 0;
                            end
                        end else if (op[11:0] == c8ic_pkg::SYS_RET) begin
                            sp = (sp == 0) ? c8ic_pkg::STACK_DEPTH - 1 : sp - 1;
                            pc = stk[sp];
                        end
                    end
                    c8ic_pkg::G_JP: pc = op[11:0];
                    c8ic_pkg::G_CALL: begin
                        stk[sp] = pc;
                        sp = (sp + 1 >= c8ic_pkg::STACK_DEPTH) ? 0 : sp + 1;
                        pc = op[11:0];
                    end
                    c8ic_pkg::G_SE_NN:  skip_when(vreg[x] == nn);
                    c8ic_pkg::G_SNE_NN: skip_when(vreg[x] != nn);
                    c8ic_pkg::G_SE_XY:  skip_when(vreg[x] == vreg[y]);
                    c8ic_pkg::G_LD_NN:  vreg[x] = nn;
                    c8ic_pkg::G_ADD_NN: vreg[x] = vreg[x] + nn;
                    c8ic_pkg::G_ALU:    run_alu(x, y, op[3:0]);
                    c8ic_pkg::G_SNE_XY: skip_when(vreg[x] != vreg[y]);
                    c8ic_pkg::G_LD_I:   ireg = {4'd0, op[11:0]};
                    c8ic_pkg::G_JP_V0:  pc = op[11:0] + {4'd0, vreg[0]};
                    c8ic_pkg::G_RND:    vreg[x] = it.random_byte & nn;
                    c8ic_pkg::G_DRW:    if (draw(x, y, op[3:0])) res.draw_flag = 1;
                    c8ic_pkg::G_KEY: begin
                        if (nn == c8ic_pkg::KEY_DOWN) skip_when(keys[vreg[x][3:0]]);
                        else if (nn == c8ic_pkg::KEY_UP) skip_when(!keys[vreg[x][3:0]]);
                    end
                    default: run_misc(x, nn);
                endcase
                res.executed_opcode = op;
                if (dt != 0) dt--;
                if (st != 0) st--;
            end
            default: begin
                base = (it.address[7:3]) * c8ic_pkg::SCREEN_WIDTH + it.address[2:0] * 8;
                for (int c = 0; c < 8; c++) res.read_data[7-c] = fb[base+c];
            end
        endcase
        res.program_counter = pc;
        res.waiting_for_key = !run;
        res.sound_on = st != 0;
        pending.push_back(res);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %0d: %s got %h want %h", checked, what, got, want);
        errors++;
    endtask

    // Compare one result transaction with the oldest expectation
    task check_result(c8ic_pkg::t_res got);
        c8ic_pkg::t_res want;
        if (pending.size() == 0) begin
            $display("unexpected result transaction");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.program_counter !== want.program_counter)
            report("program_counter", got.program_counter, want.program_counter);
        if (got.executed_opcode !== want.executed_opcode)
            report("executed_opcode", got.executed_opcode, want.executed_opcode);
        if (got.draw_flag !== want.draw_flag) report("draw_flag", got.draw_flag, want.draw_flag);
        if (got.waiting_for_key !== want.waiting_for_key)
            report("waiting_for_key", got.waiting_for_key, want.waiting_for_key);
        if (got.sound_on !== want.sound_on) report("sound_on", got.sound_on, want.sound_on);
        if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
        checked++;
    endtask
endclass

module tb_top;
    logic i_clk = 0;
    logic i_rst_n = 0;

    c8ic_in_if  in_if();
    c8ic_out_if out_if();

    chip8_instruction_core_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    c8_scoreboard board = new();
    int  hold_off = 0;      // long receiver stall requested by the stimulus
    bit  stim_done = 0;
    int  n_sent = 0;
    int  n_exec = 0;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    initial begin
        in_if.valid = 0; in_if.operation = '0; in_if.address = '0; in_if.data_byte = '0;
        in_if.key_index = '0; in_if.key_down = 0; in_if.random_byte = '0;
        out_if.ready = 0;
    end

    // Offer one transaction and wait for acceptance
    task automatic send(c8ic_pkg::t_op op, logic [11:0] addr, logic [7:0] data,
                        logic [3:0] key, bit down);
        int gap;
        c8ic_pkg::t_item it;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1;
        in_if.operation   <= op;
        in_if.address     <= addr;
        in_if.data_byte   <= data;
        in_if.key_index   <= key;
        in_if.key_down    <= down;
        in_if.random_byte <= 8'($urandom_range(0, 255));
        do @(posedge i_clk); while (!(in_if.ready === 1'b1));
        it.operation = op; it.address = addr; it.data_byte = data;
        it.key_index = key; it.key_down = down; it.random_byte = in_if.random_byte;
        board.note_item(it);
        n_sent++;
        if (op == c8ic_pkg::OP_EXEC) n_exec++;
    endtask

    // Write an opcode at the given address, then execute from the program counter
    task automatic put_op(logic [11:0] addr, logic [15:0] op);
        send(c8ic_pkg::OP_MEM_WR, addr, op[15:8], '0, 0);
        send(c8ic_pkg::OP_MEM_WR, addr + 12'd1, op[7:0], '0, 0);
    endtask

    task automatic run_op(logic [15:0] op);
        put_op(board.pc, op);
        send(c8ic_pkg::OP_EXEC, '0, '0, '0, 0);
    endtask

    task automatic drain();
        in_if.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_op();
        logic [15:0] op;
        op = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0: op[15:12] = c8ic_pkg::G_ALU;
            1: op = {c8ic_pkg::G_MISC, op[11:8],
                     8'(c8ic_pkg::MISC_STORE + 8'($urandom_range(0, 1) * 16))};
            2: op = {c8ic_pkg::G_MISC, op[11:8], c8ic_pkg::MISC_BCD};
            3: op = {c8ic_pkg::G_DRW, op[11:4], 4'($urandom_range(0, 4))};
            4: op = {c8ic_pkg::G_KEY, op[11:8],
                     $urandom_range(0, 1) ? c8ic_pkg::KEY_DOWN : c8ic_pkg::KEY_UP};
            5: op = {c8ic_pkg::G_MISC, op[11:8],
                     $urandom_range(0, 1) ? c8ic_pkg::MISC_SET_ST : c8ic_pkg::MISC_ADD_I};
            6: op = {c8ic_pkg::G_SYS, $urandom_range(0, 1) ? c8ic_pkg::SYS_RET : op[11:0]};
            7: op[15:12] = c8ic_pkg::G_LD_NN;
            default: ;
        endcase
        if (op == {c8ic_pkg::G_SYS, c8ic_pkg::SYS_CLS} && $urandom_range(0, 3) != 0)
            op[15:12] = c8ic_pkg::G_LD_NN;
        return op;
    endfunction

    initial begin
        logic [15:0] dir [$];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        // Directed: every group but 7XNN, flag cases, wraps, draw/clear, key wait
        dir = {16'h60FF, 16'h6101, 16'h8014, 16'h8015, 16'h8107, 16'h8016, 16'h801E,
               16'h8011, 16'h8012, 16'h8013, 16'h8010, 16'h8018, 16'hA0FF, 16'hF01E,
               16'hF029, 16'hF033, 16'hF255, 16'hF265, 16'hD015, 16'hD015, 16'hD010,
               16'hD01F, 16'h00E0, 16'h00E0, 16'hF018, 16'hF015, 16'hF007, 16'hC0FF,
               16'h3000, 16'h4000, 16'h5010, 16'h9010, 16'hE09E, 16'hE0A1, 16'hE0FF,
               16'hF0FF, 16'h0123, 16'hAFFE, 16'hF355};
        foreach (dir[i]) run_op(dir[i]);
        send(c8ic_pkg::OP_FB_RD, 12'hFFF, '0, '0, 0);
        send(c8ic_pkg::OP_FB_RD, 12'h000, '0, '0, 0);
        send(c8ic_pkg::OP_KEY, '0, '0, 4'hF, 1);
        run_op(16'h6F0F); run_op(16'hEF9E); run_op(16'hEFA1);
        run_op(16'hF00A);
        send(c8ic_pkg::OP_EXEC, '0, '0, '0, 0);
        send(c8ic_pkg::OP_KEY, '0, '0, 4'hF, 0);
        send(c8ic_pkg::OP_EXEC, '0, '0, '0, 0);
        send(c8ic_pkg::OP_KEY, '0, '0, 4'h3, 1);
        // Calls past the stack depth and returns back through it
        for (int i = 0; i < c8ic_pkg::STACK_DEPTH + 1; i++)
            run_op({c8ic_pkg::G_CALL, 12'h300 + 12'(i * 4)});
        for (int i = 0; i < c8ic_pkg::STACK_DEPTH + 2; i++)
            run_op({c8ic_pkg::G_SYS, c8ic_pkg::SYS_RET});
        run_op(16'h1FFE); run_op(16'h6000); run_op(16'hBFFF);
        drain();
        // Long receiver stall while the sender keeps offering transactions
        hold_off = 400;
        for (int i = 0; i < 20; i++) run_op(16'h7001);
        // Random: mostly generated programs, some memory noise, keys and reads
        while (n_sent < 1700) begin
            case ($urandom_range(0, 19))
                0: send(c8ic_pkg::OP_MEM_WR, 12'($urandom_range(0, 4095)),
                        8'($urandom_range(0, 255)), '0, 0);
                1, 2: send(c8ic_pkg::OP_KEY, 12'($urandom), '0, 4'($urandom_range(0, 15)),
                           1'($urandom_range(0, 1)));
                3: send(c8ic_pkg::OP_FB_RD, 12'($urandom_range(0, 4095)), '0, '0, 0);
                4: send(c8ic_pkg::OP_EXEC, 12'($urandom), 8'($urandom), '0, 0);
                5: if (board.pc > 12'hFF0 || board.pc < 12'h200)
                       run_op({c8ic_pkg::G_JP, 12'h200});
                   else run_op({c8ic_pkg::G_SYS, c8ic_pkg::SYS_CLS});
                default: run_op(rand_op());
            endcase
            if (n_sent % 600 < 3) drain();
        end
        in_if.valid <= 0;
        stim_done = 1;
    end

    // Result side: random stalls, plus one long hold-off
    initial begin
        c8ic_pkg::t_res r;
        int   gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_off > 0) begin
                out_if.ready <= 0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                out_if.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1;
            do @(posedge i_clk); while (!(out_if.valid === 1'b1));
            r.program_counter = out_if.program_counter;
            r.executed_opcode = out_if.executed_opcode;
            r.draw_flag       = out_if.draw_flag;
            r.waiting_for_key = out_if.waiting_for_key;
            r.sound_on        = out_if.sound_on;
            r.read_data       = out_if.read_data;
            board.check_result(r);
        end
    end

    initial begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("covered %0d transactions, %0d executes, %0d results checked",
                 n_sent, n_exec, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
